@@ rtl/udprt_pkg.sv @@
// Shared types and constants for the UDP chunk reassembly tracker.
package udprt_pkg;

   localparam logic [3:0] STAT_WHOLE     = 4'd0;
   localparam logic [3:0] STAT_SHORT     = 4'd1;
   localparam logic [3:0] STAT_MAGIC     = 4'd2;
   localparam logic [3:0] STAT_LEN       = 4'd3;
   localparam logic [3:0] STAT_COUNT     = 4'd4;
   localparam logic [3:0] STAT_STALE     = 4'd5;
   localparam logic [3:0] STAT_CONFLICT  = 4'd6;
   localparam logic [3:0] STAT_DUP       = 4'd7;
   localparam logic [3:0] STAT_ACCEPT    = 4'd8;
   localparam logic [3:0] STAT_COMPLETE  = 4'd9;
   localparam logic [3:0] STAT_TICK      = 4'd10;
   localparam logic [3:0] STAT_TOO_MANY  = 4'd11;

   localparam logic [1:0] REG_MAGIC   = 2'd0;
   localparam logic [1:0] REG_STALE   = 2'd1;
   localparam logic [1:0] REG_TIMEOUT = 2'd2;
   localparam logic [1:0] REG_PERIOD  = 2'd3;

   localparam logic [31:0] MAGIC_RESET   = 32'hA0B0C0D0;
   localparam logic [9:0]  STALE_RESET   = 10'd50;
   localparam logic [15:0] TIMEOUT_RESET = 16'd350;
   localparam logic [7:0]  PERIOD_RESET  = 8'd40;

   localparam logic [16:0] HDR_LEN      = 17'd14;
   localparam logic [15:0] WHOLE_MARKER = 16'hFFD8;
   localparam int          SLOT_ID_W    = 8;

   typedef struct packed {
      logic                 wr;
      logic                 wr_valid;
      logic                 keep_start;
      logic                 sweep;
      logic [SLOT_ID_W-1:0] slot;
      logic [31:0]          frame;
      logic [31:0]          now;
      logic [15:0]          timeout;
   } cell_cmd_type;

   typedef struct packed {
      logic                 have;
      logic [31:0]          age;
      logic [SLOT_ID_W-1:0] idx;
   } token_type;

endpackage

@@ rtl/udprt_cell.sv @@
// One slot of the reassembly table plus its stage of the oldest-slot chain.
module udprt_cell import udprt_pkg::*; #(
   parameter int IDX        = 0,
   parameter int MAX_CHUNKS = 64,
   parameter int CNT_W      = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [CNT_W-1:0]      wr_total,
   input  logic [MAX_CHUNKS-1:0] wr_bitmap,
   input  logic [CNT_W-1:0]      wr_received,
   input  token_type             prev_tok,
   output token_type             next_tok,
   output logic                  valid,
   output logic                  match,
   output logic [CNT_W-1:0]      total,
   output logic [MAX_CHUNKS-1:0] bitmap,
   output logic [CNT_W-1:0]      received
);

   logic                  valid_ff;
   logic [31:0]           frame_ff;
   logic [CNT_W-1:0]      total_ff;
   logic [MAX_CHUNKS-1:0] bitmap_ff;
   logic [CNT_W-1:0]      received_ff;
   logic [31:0]           start_ff;
   token_type             tok_ff;
   token_type             tok_in;
   logic [31:0]           age;
   logic                  hit;

   assign age = cmd.now - start_ff;
   assign hit = cmd.wr && (cmd.slot == SLOT_ID_W'(IDX));

   always_comb begin
      if (!prev_tok.have || age > prev_tok.age) begin
         tok_in = '{have: 1'b1, age: age, idx: SLOT_ID_W'(IDX)};
      end else begin
         tok_in = prev_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         tok_ff <= tok_in;
         if (hit) begin
            valid_ff <= cmd.wr_valid;
         end else if (cmd.sweep && valid_ff && age > {16'd0, cmd.timeout}) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         frame_ff    <= cmd.frame;
         total_ff    <= wr_total;
         bitmap_ff   <= wr_bitmap;
         received_ff <= wr_received;
         if (!cmd.keep_start) begin
            start_ff <= cmd.now;
         end
      end
   end

   assign next_tok = tok_ff;
   assign valid    = valid_ff;
   assign match    = valid_ff && (frame_ff == cmd.frame);
   assign total    = total_ff;
   assign bitmap   = bitmap_ff;
   assign received = received_ff;

endmodule

@@ rtl/udp_chunk_reassembly_tracker_unit.sv @@
// Flow: ticks and rejects go S_CHK, S_DONE; known or free slots go S_CHK, S_APPLY, S_DONE;
//   a full table adds S_SCAN before S_APPLY (the oldest-slot token walks the cell chain), a sweep adds S_SWEEP.
// One transaction at a time; the next is taken once the result is registered.
// Timeout sweep checks all cells at once, in the S_SWEEP state. No clearing pass is needed.
// Reset (synchronous, active high) clears slot valid bits, time, latest shown frame,
//   the sweep counter and loads the register defaults.
module udp_chunk_reassembly_tracker_unit import udprt_pkg::*; #(
   parameter int SLOTS      = 32,
   parameter int MAX_CHUNKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [16:0] req_datagram_len,
   input  logic [31:0] req_lead_word,
   input  logic [31:0] req_frame_number,
   input  logic [15:0] req_chunk_index,
   input  logic [15:0] req_chunk_total,
   input  logic [15:0] req_payload_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [4:0]  rsp_slot_index,
   output logic [31:0] rsp_frame_out,
   output logic [15:0] rsp_chunk_out,
   output logic [6:0]  rsp_received_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int SIDX_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(MAX_CHUNKS + 1);
   localparam int BIT_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
   localparam int SCNT_W = $clog2(SLOTS);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHK   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_APPLY = 3'd3;
   localparam logic [2:0] S_SWEEP = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [SCNT_W-1:0] scan_ff, scan_in;

   logic [31:0] magic_ff;
   logic [9:0]  stale_ff;
   logic [15:0] timeout_ff;
   logic [7:0]  period_ff;
   logic [31:0] now_ff, now_in;
   logic [31:0] latest_ff, latest_in;
   logic [7:0]  sweep_cnt_ff, sweep_cnt_in;

   logic        mode_ff;
   logic [16:0] len_ff;
   logic [31:0] lead_ff, fr_ff;
   logic [15:0] ci_ff, ct_ff, pl_ff;

   logic [SIDX_W-1:0] sel_ff, sel_in;
   logic              found_ff, found_in;

   logic [3:0]        res_status_ff, res_status_in;
   logic [SIDX_W-1:0] res_slot_ff, res_slot_in;
   logic [31:0]       res_frame_ff, res_frame_in;
   logic [15:0]       res_chunk_ff, res_chunk_in;
   logic [CNT_W-1:0]  res_rc_ff, res_rc_in;

   logic        out_valid_ff;
   logic [3:0]  out_status_ff;
   logic [4:0]  out_slot_ff;
   logic [31:0] out_frame_ff;
   logic [15:0] out_chunk_ff;
   logic [6:0]  out_rc_ff;

   cell_cmd_type          cmd;
   logic [CNT_W-1:0]      wr_total;
   logic [MAX_CHUNKS-1:0] wr_bitmap;
   logic [CNT_W-1:0]      wr_received;
   token_type             tok [SLOTS];
   logic [SLOTS-1:0]      cell_valid, cell_match;
   logic [CNT_W-1:0]      cell_total    [SLOTS];
   logic [MAX_CHUNKS-1:0] cell_bitmap   [SLOTS];
   logic [CNT_W-1:0]      cell_received [SLOTS];

   logic                  req_take;
   logic                  match_any, free_any;
   logic [SIDX_W-1:0]     match_idx, free_idx;
   logic [CNT_W-1:0]      ct_n, cur_total, cur_rc, new_rc;
   logic [MAX_CHUNKS-1:0] cur_bm, new_bm;
   logic [BIT_W-1:0]      bitpos;
   logic                  conflict, dup, complete;
   logic [31:0]           stale_sum;
   logic [7:0]            sweep_next;
   logic [SIDX_W+4:0]     slot_ext;
   logic [CNT_W+6:0]      rc_ext;

   genvar g;
   generate
      for (g = 0; g < SLOTS; g++) begin : g_cell
         token_type prev;
         if (g == 0) begin : g_head
            assign prev = '0;
         end else begin : g_link
            assign prev = tok[g-1];
         end
         udprt_cell #(.IDX(g), .MAX_CHUNKS(MAX_CHUNKS), .CNT_W(CNT_W)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .wr_total    (wr_total),
            .wr_bitmap   (wr_bitmap),
            .wr_received (wr_received),
            .prev_tok    (prev),
            .next_tok    (tok[g]),
            .valid       (cell_valid[g]),
            .match       (cell_match[g]),
            .total       (cell_total[g]),
            .bitmap      (cell_bitmap[g]),
            .received    (cell_received[g])
         );
      end
   endgenerate

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      match_any = 1'b0;
      free_any  = 1'b0;
      match_idx = '0;
      free_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (cell_match[i]) begin
            match_any = 1'b1;
            match_idx = SIDX_W'(i);
         end
         if (!cell_valid[i]) begin
            free_any = 1'b1;
            free_idx = SIDX_W'(i);
         end
      end
   end

   assign ct_n      = ct_ff[CNT_W-1:0];
   assign bitpos    = ci_ff[BIT_W-1:0];
   assign cur_total = found_ff ? cell_total[sel_ff] : ct_n;
   assign cur_bm    = found_ff ? cell_bitmap[sel_ff] : '0;
   assign cur_rc    = found_ff ? cell_received[sel_ff] : '0;
   assign conflict  = found_ff && (cur_total != ct_n);
   assign dup       = cur_bm[bitpos];
   assign new_bm    = cur_bm | (MAX_CHUNKS'(1) << bitpos);
   assign new_rc    = cur_rc + CNT_W'(!dup);
   assign complete  = (new_rc == cur_total);
   assign stale_sum = fr_ff + {22'd0, stale_ff};
   assign sweep_next = sweep_cnt_ff + 8'd1;

   always_comb begin
      cmd.wr         = (state_ff == S_APPLY);
      cmd.wr_valid   = !conflict && !complete;
      cmd.keep_start = found_ff;
      cmd.sweep      = (state_ff == S_SWEEP);
      cmd.slot       = SLOT_ID_W'(sel_ff);
      cmd.frame      = fr_ff;
      cmd.now        = now_ff;
      cmd.timeout    = timeout_ff;
      wr_total       = ct_n;
      wr_bitmap      = new_bm;
      wr_received    = new_rc;
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      now_in        = now_ff;
      latest_in     = latest_ff;
      sweep_cnt_in  = sweep_cnt_ff;
      sel_in        = sel_ff;
      found_in      = found_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_frame_in  = res_frame_ff;
      res_chunk_in  = res_chunk_ff;
      res_rc_in     = res_rc_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            res_slot_in  = '0;
            res_frame_in = fr_ff;
            res_chunk_in = ci_ff;
            res_rc_in    = '0;
            state_in     = S_DONE;
            priority if (mode_ff) begin
               now_in        = now_ff + 32'd1;
               res_status_in = STAT_TICK;
               res_frame_in  = '0;
               res_chunk_in  = '0;
            end else if (len_ff >= 17'd2 && lead_ff[31:16] == WHOLE_MARKER) begin
               res_status_in = STAT_WHOLE;
               res_frame_in  = '0;
               res_chunk_in  = '0;
            end else if (len_ff < HDR_LEN) begin
               res_status_in = STAT_SHORT;
               res_frame_in  = '0;
               res_chunk_in  = '0;
            end else if (lead_ff != magic_ff) begin
               res_status_in = STAT_MAGIC;
            end else if ((HDR_LEN + {1'b0, pl_ff}) != len_ff) begin
               res_status_in = STAT_LEN;
            end else if (ct_ff == 16'd0 || ci_ff >= ct_ff) begin
               res_status_in = STAT_COUNT;
            end else if ({16'd0, ct_ff} > 32'(MAX_CHUNKS)) begin
               res_status_in = STAT_TOO_MANY;
            end else if (latest_ff != 32'd0 && stale_sum < latest_ff) begin
               res_status_in = STAT_STALE;
            end else if (match_any) begin
               found_in = 1'b1;
               sel_in   = match_idx;
               state_in = S_APPLY;
            end else if (free_any) begin
               found_in = 1'b0;
               sel_in   = free_idx;
               state_in = S_APPLY;
            end else begin
               found_in = 1'b0;
               scan_in  = SCNT_W'(SLOTS - 1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_ff == '0) begin
               sel_in   = tok[SLOTS-1].idx[SIDX_W-1:0];
               state_in = S_APPLY;
            end else begin
               scan_in = scan_ff - SCNT_W'(1);
            end
         end
         S_APPLY: begin
            res_slot_in = sel_ff;
            state_in    = S_DONE;
            if (conflict) begin
               res_status_in = STAT_CONFLICT;
               res_rc_in     = '0;
            end else begin
               res_rc_in     = new_rc;
               res_status_in = complete ? STAT_COMPLETE : (dup ? STAT_DUP : STAT_ACCEPT);
               if (complete && fr_ff > latest_ff) begin
                  latest_in = fr_ff;
               end
               if (sweep_next == period_ff) begin
                  sweep_cnt_in = '0;
                  state_in     = S_SWEEP;
               end else begin
                  sweep_cnt_in = sweep_next;
               end
            end
         end
         S_SWEEP: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         now_ff       <= '0;
         latest_ff    <= '0;
         sweep_cnt_ff <= '0;
         magic_ff     <= MAGIC_RESET;
         stale_ff     <= STALE_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         period_ff    <= PERIOD_RESET;
         found_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         now_ff       <= now_in;
         latest_ff    <= latest_in;
         sweep_cnt_ff <= sweep_cnt_in;
         found_ff     <= found_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_MAGIC:   magic_ff   <= csr_data;
               REG_STALE:   stale_ff   <= csr_data[9:0];
               REG_TIMEOUT: timeout_ff <= csr_data[15:0];
               REG_PERIOD:  period_ff  <= csr_data[7:0];
               default:     magic_ff   <= magic_ff;
            endcase
         end
         if (state_ff == S_DONE && (!out_valid_ff || !rsp_stall)) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign slot_ext = {5'd0, res_slot_ff};
   assign rc_ext   = {7'd0, res_rc_ff};

   always_ff @(posedge clock) begin
      if (req_take) begin
         mode_ff <= req_mode;
         len_ff  <= req_datagram_len;
         lead_ff <= req_lead_word;
         fr_ff   <= req_frame_number;
         ci_ff   <= req_chunk_index;
         ct_ff   <= req_chunk_total;
         pl_ff   <= req_payload_bytes;
      end
      sel_ff        <= sel_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_frame_ff  <= res_frame_in;
      res_chunk_ff  <= res_chunk_in;
      res_rc_ff     <= res_rc_in;
      if (state_ff == S_DONE && (!out_valid_ff || !rsp_stall)) begin
         out_status_ff <= res_status_ff;
         out_slot_ff   <= slot_ext[4:0];
         out_frame_ff  <= res_frame_ff;
         out_chunk_ff  <= res_chunk_ff;
         out_rc_ff     <= rc_ext[6:0];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_slot_index     = out_slot_ff;
   assign rsp_frame_out      = out_frame_ff;
   assign rsp_chunk_out      = out_chunk_ff;
   assign rsp_received_count = out_rc_ff;

`ifndef SYNTHESIS
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) |-> $onehot0(cell_match))
      else $error("two slots hold the same frame");

   a_scan_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (&cell_valid))
      else $error("oldest-slot scan with a free slot");

   a_found_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY && found_ff) |-> cell_valid[sel_ff])
      else $error("matched slot is not valid");

   a_latest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_status_ff == STAT_COMPLETE) |-> (latest_ff >= res_frame_ff))
      else $error("latest shown frame not advanced on completion");
`endif

endmodule

@@ test/udp_chunk_reassembly_tracker_unit_test.sv @@
// Self-checking testbench for the UDP chunk reassembly tracker unit.
module udp_chunk_reassembly_tracker_unit_test import udprt_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        mode;
      logic [16:0] len;
      logic [31:0] lead;
      logic [31:0] frame;
      logic [15:0] ci;
      logic [15:0] ct;
      logic [15:0] pl;
   } dgram_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [4:0]  slot;
      logic [31:0] frame;
      logic [15:0] chunk;
      logic [6:0]  rcnt;
   } verdict_type;

   typedef struct packed {
      dgram_type   it;
      logic        typed;
      verdict_type res;
   } row_type;

   typedef struct {
      logic [31:0] magic;
      logic [9:0]  stale;
      logic [15:0] tmo;
      logic [7:0]  period;
      int          n;
      int          pool;
      bit          rnd;
      bit          jump;
      bit          hold;
   } phase_type;

   localparam int NSLOT = 32;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_mode;
   logic [16:0] req_datagram_len;
   logic [31:0] req_lead_word;
   logic [31:0] req_frame_number;
   logic [15:0] req_chunk_index;
   logic [15:0] req_chunk_total;
   logic [15:0] req_payload_bytes;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_status;
   logic [4:0]  rsp_slot_index;
   logic [31:0] rsp_frame_out;
   logic [15:0] rsp_chunk_out;
   logic [6:0]  rsp_received_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;

   udp_chunk_reassembly_tracker_unit u_dut (.*);

   // tracker shadow state
   logic [31:0] m_magic;
   logic [9:0]  m_stale;
   logic [15:0] m_timeout;
   logic [7:0]  m_period;
   bit          sl_valid[NSLOT];
   logic [31:0] sl_frame[NSLOT];
   logic [6:0]  sl_total[NSLOT];
   logic [63:0] sl_bitmap[NSLOT];
   logic [6:0]  sl_recv[NSLOT];
   logic [31:0] sl_start[NSLOT];
   logic [31:0] now_ms;
   logic [31:0] latest_shown;
   logic [7:0]  sweep_cnt;

   verdict_type pending_verdicts[$];
   int          errors;
   int          status_seen[12];
   int          n_items;
   bit          quiet;
   bit          long_hold;

   logic [31:0] pool_fr[40];
   int          pool_ct[40];
   int          npool;
   logic [31:0] next_frame;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("TB_ERROR");
      $finish;
   end

   function automatic verdict_type track_chunk(dgram_type it);
      verdict_type r;
      int          s;
      bit          found;
      bit          have;
      logic [31:0] age;
      logic [31:0] best_age;
      logic [31:0] reach;
      r = '0;
      if (it.mode) begin
         now_ms++;
         r.status = STAT_TICK;
         return r;
      end
      if (it.len >= 2 && it.lead[31:16] == WHOLE_MARKER) begin
         r.status = STAT_WHOLE;
         return r;
      end
      if (it.len < HDR_LEN) begin
         r.status = STAT_SHORT;
         return r;
      end
      r.frame = it.frame;
      r.chunk = it.ci;
      if (it.lead != m_magic) begin
         r.status = STAT_MAGIC;
         return r;
      end
      if ({1'b0, it.pl} + HDR_LEN != it.len) begin
         r.status = STAT_LEN;
         return r;
      end
      if (it.ct == 0 || it.ci >= it.ct) begin
         r.status = STAT_COUNT;
         return r;
      end
      if (it.ct > 64) begin
         r.status = STAT_TOO_MANY;
         return r;
      end
      reach = it.frame + {22'd0, m_stale};
      if (latest_shown != 0 && reach < latest_shown) begin
         r.status = STAT_STALE;
         return r;
      end
      found = 1'b0;
      s = -1;
      for (int i = 0; i < NSLOT; i++)
         if (!found && sl_valid[i] && sl_frame[i] == it.frame) begin
            found = 1'b1;
            s = i;
         end
      if (!found) begin
         for (int i = 0; i < NSLOT; i++)
            if (s < 0 && !sl_valid[i]) s = i;
         if (s < 0) begin
            have = 1'b0;
            best_age = '0;
            for (int i = 0; i < NSLOT; i++) begin
               age = now_ms - sl_start[i];
               if (!have || age > best_age) begin
                  have = 1'b1;
                  s = i;
                  best_age = age;
               end
            end
         end
         sl_valid[s] = 1'b1;
         sl_frame[s] = it.frame;
         sl_total[s] = it.ct[6:0];
         sl_bitmap[s] = '0;
         sl_recv[s] = '0;
         sl_start[s] = now_ms;
      end
      r.slot = s[4:0];
      if ({9'd0, sl_total[s]} != it.ct) begin
         sl_valid[s] = 1'b0;
         r.status = STAT_CONFLICT;
         return r;
      end
      if (sl_bitmap[s][it.ci[5:0]]) r.status = STAT_DUP;
      else begin
         sl_bitmap[s][it.ci[5:0]] = 1'b1;
         sl_recv[s]++;
         r.status = STAT_ACCEPT;
      end
      r.rcnt = sl_recv[s];
      if (sl_recv[s] == sl_total[s]) begin
         r.status = STAT_COMPLETE;
         sl_valid[s] = 1'b0;
         if (it.frame > latest_shown) latest_shown = it.frame;
      end
      sweep_cnt++;
      if (sweep_cnt == m_period) begin
         sweep_cnt = '0;
         for (int i = 0; i < NSLOT; i++)
            if (sl_valid[i] && (now_ms - sl_start[i]) > {16'd0, m_timeout}) sl_valid[i] = 1'b0;
      end
      return r;
   endfunction

   function automatic void refill_pool(int k);
      pool_fr[k] = next_frame;
      next_frame += $urandom_range(1, 3);
      pool_ct[k] = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 6);
   endfunction

   function automatic dgram_type make_datagram();
      dgram_type it;
      int        k;
      int        pick;
      pick = $urandom_range(0, 99);
      it.mode = 1'b0;
      it.len = 17'($urandom_range(0, 65536));
      it.lead = $urandom;
      it.frame = $urandom;
      it.ci = 16'($urandom_range(0, 65535));
      it.ct = 16'($urandom_range(0, 65535));
      it.pl = 16'($urandom_range(0, 65535));
      if (pick < 8) it.mode = 1'b1;
      else if (pick < 80) begin
         k = $urandom_range(0, npool - 1);
         if ($urandom_range(0, 2 * pool_ct[k] + 3) == 0) refill_pool(k);
         it.frame = pool_fr[k];
         it.ct = 16'(pool_ct[k]);
         if ($urandom_range(0, 24) == 0) it.ct = 16'($urandom_range(1, 64));
         it.ci = 16'($urandom_range(0, it.ct - 1));
         it.pl = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65522))
                                               : 16'($urandom_range(0, 1500));
         it.len = 17'(it.pl) + HDR_LEN;
         it.lead = m_magic;
      end else begin
         case ($urandom_range(0, 6))
            1: it.lead = {WHOLE_MARKER, 16'($urandom)};
            2: it.len = 17'($urandom_range(0, 13));
            3: it.lead = m_magic;
            4, 5, 6: begin
               it.lead = m_magic;
               it.pl = 16'($urandom_range(0, 1000));
               it.len = 17'(it.pl) + HDR_LEN;
               if (pick < 90 && latest_shown > 200) begin
                  it.ct = 16'($urandom_range(1, 64));
                  it.ci = 16'($urandom_range(0, it.ct - 1));
                  it.frame = latest_shown - {22'd0, m_stale} - $urandom_range(1, 100);
               end else if (pick < 95) begin
                  it.ct = 16'($urandom_range(65, 65535));
                  it.ci = 16'($urandom_range(0, 64));
               end
            end
            default: ;
         endcase
      end
      return it;
   endfunction

   task automatic send_datagram(dgram_type it, bit typed, verdict_type res);
      int          gap;
      verdict_type v;
      gap = quiet ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode <= it.mode;
      req_datagram_len <= it.len;
      req_lead_word <= it.lead;
      req_frame_number <= it.frame;
      req_chunk_index <= it.ci;
      req_chunk_total <= it.ct;
      req_payload_bytes <= it.pl;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      v = track_chunk(it);
      pending_verdicts.insert(pending_verdicts.size(), typed ? res : v);
      n_items++;
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_MAGIC:   m_magic = value;
         REG_STALE:   m_stale = value[9:0];
         REG_TIMEOUT: m_timeout = value[15:0];
         REG_PERIOD:  m_period = value[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // receiver backpressure
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         if (long_hold) begin
            n = 400;
            long_hold = 1'b0;
         end else n = quiet ? 0 : $urandom_range(0, 16);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $error("result with no transaction outstanding: status %0d", rsp_status);
            errors++;
         end else begin
            e = pending_verdicts.pop_front();
            if (rsp_status < 12) status_seen[rsp_status]++;
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_slot_index !== e.slot) begin
               $error("slot_index exp %0d got %0d", e.slot, rsp_slot_index);
               errors++;
            end
            if (rsp_frame_out !== e.frame) begin
               $error("frame_out exp %h got %h", e.frame, rsp_frame_out);
               errors++;
            end
            if (rsp_chunk_out !== e.chunk) begin
               $error("chunk_out exp %0d got %0d", e.chunk, rsp_chunk_out);
               errors++;
            end
            if (rsp_received_count !== e.rcnt) begin
               $error("received_count exp %0d got %0d", e.rcnt, rsp_received_count);
               errors++;
            end
         end
      end
   end

   initial begin
      row_type     rows[19];
      phase_type   phases[5];
      phase_type   ph;
      logic [31:0] mg;
      errors = 0;
      n_items = 0;
      quiet = 1'b0;
      long_hold = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_datagram_len = '0;
      req_lead_word = '0;
      req_frame_number = '0;
      req_chunk_index = '0;
      req_chunk_total = '0;
      req_payload_bytes = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      m_magic = MAGIC_RESET;
      m_stale = STALE_RESET;
      m_timeout = TIMEOUT_RESET;
      m_period = PERIOD_RESET;
      foreach (sl_valid[i]) sl_valid[i] = 1'b0;
      now_ms = '0;
      latest_shown = '0;
      sweep_cnt = '0;
      next_frame = 32'd2000;
      mg = MAGIC_RESET;

      //        mode len        lead          frame         ci       ct       pl
      rows[0] = '{'{1'b1, 17'd0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
                  '{STAT_TICK, 5'd0, 32'd0, 16'd0, 7'd0}};
      rows[1] = '{'{1'b0, 17'd2, 32'hFFD8_0000, 32'h7, 16'h0, 16'h1, 16'h0}, 1'b1,
                  '{STAT_WHOLE, 5'd0, 32'd0, 16'd0, 7'd0}};
      rows[2] = '{'{1'b0, 17'd13, mg, 32'h7, 16'h0, 16'h1, 16'h0}, 1'b1,
                  '{STAT_SHORT, 5'd0, 32'd0, 16'd0, 7'd0}};
      rows[3] = '{'{1'b0, 17'd14, 32'h0, 32'h5, 16'h0, 16'h1, 16'h0}, 1'b1,
                  '{STAT_MAGIC, 5'd0, 32'd5, 16'd0, 7'd0}};
      rows[4] = '{'{1'b0, 17'd65536, mg, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                  1'b1, '{STAT_LEN, 5'd0, 32'hFFFF_FFFF, 16'hFFFF, 7'd0}};
      rows[5] = '{'{1'b0, 17'd14, mg, 32'h1, 16'h0, 16'h0, 16'h0}, 1'b1,
                  '{STAT_COUNT, 5'd0, 32'd1, 16'd0, 7'd0}};
      rows[6] = '{'{1'b0, 17'd14, mg, 32'h1, 16'h0, 16'd65, 16'h0}, 1'b1,
                  '{STAT_TOO_MANY, 5'd0, 32'd1, 16'd0, 7'd0}};
      rows[7] = '{'{1'b0, 17'd114, mg, 32'd10, 16'h0, 16'd2, 16'd100}, 1'b1,
                  '{STAT_ACCEPT, 5'd0, 32'd10, 16'd0, 7'd1}};
      rows[8] = '{'{1'b0, 17'd114, mg, 32'd10, 16'h0, 16'd2, 16'd100}, 1'b1,
                  '{STAT_DUP, 5'd0, 32'd10, 16'd0, 7'd1}};
      rows[9] = '{'{1'b0, 17'd14, mg, 32'd10, 16'd1, 16'd3, 16'd0}, 1'b1,
                  '{STAT_CONFLICT, 5'd0, 32'd10, 16'd1, 7'd0}};
      rows[10] = '{'{1'b0, 17'd14, mg, 32'd10, 16'd0, 16'd1, 16'd0}, 1'b1,
                   '{STAT_COMPLETE, 5'd0, 32'd10, 16'd0, 7'd1}};
      rows[11] = '{'{1'b0, 17'd14, mg, 32'd20, 16'd63, 16'd64, 16'd0}, 1'b1,
                   '{STAT_ACCEPT, 5'd0, 32'd20, 16'd63, 7'd1}};
      rows[12] = '{'{1'b0, 17'd65536, mg, 32'd30, 16'd0, 16'd1, 16'd65522}, 1'b1,
                   '{STAT_COMPLETE, 5'd1, 32'd30, 16'd0, 7'd1}};
      rows[13] = '{'{1'b0, 17'd14, mg, 32'd1000, 16'd0, 16'd1, 16'd0}, 1'b0, '0};
      rows[14] = '{'{1'b0, 17'd14, mg, 32'd900, 16'd0, 16'd1, 16'd0}, 1'b1,
                   '{STAT_STALE, 5'd0, 32'd900, 16'd0, 7'd0}};
      rows[15] = '{'{1'b0, 17'd14, mg, 32'd0, 16'd0, 16'd1, 16'd0}, 1'b1,
                   '{STAT_STALE, 5'd0, 32'd0, 16'd0, 7'd0}};
      rows[16] = '{'{1'b0, 17'd14, mg, 32'hFFFF_FFFF, 16'd1, 16'd2, 16'd0}, 1'b1,
                   '{STAT_STALE, 5'd0, 32'hFFFF_FFFF, 16'd1, 7'd0}};
      rows[17] = '{'{1'b0, 17'd21, mg, 32'd970, 16'd1, 16'd2, 16'd7}, 1'b0, '0};
      rows[18] = '{'{1'b0, 17'd1, 32'hFFD8_FFFF, 32'h0, 16'h0, 16'h0, 16'h0}, 1'b1,
                   '{STAT_SHORT, 5'd0, 32'd0, 16'd0, 7'd0}};

      phases[0] = '{32'hFFFF_FFFF, 10'd1023, 16'hFFFF, 8'd255, 400, 4, 0, 0, 1};
      phases[1] = '{32'h0, 10'd0, 16'd0, 8'd1, 250, 40, 0, 0, 0};
      phases[2] = '{32'hFFD8_1234, 10'd5, 16'd20, 8'd3, 100, 4, 0, 0, 0};
      phases[3] = '{32'h0, 10'd0, 16'd0, 8'd1, 400, 40, 1, 0, 0};
      phases[4] = '{MAGIC_RESET, STALE_RESET, TIMEOUT_RESET, PERIOD_RESET, 480, 12,
                    0, 1, 0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_datagram(rows[i].it, rows[i].typed, rows[i].res);
      drain();

      foreach (phases[p]) begin
         ph = phases[p];
         if (ph.rnd) begin
            ph.magic = $urandom;
            ph.stale = 10'($urandom_range(0, 1023));
            ph.tmo = 16'($urandom_range(100, 500));
            ph.period = 8'($urandom_range(1, 60));
         end
         if (ph.jump) next_frame = 32'hFFFF_F000;
         write_csr(REG_MAGIC, ph.magic);
         write_csr(REG_STALE, {22'd0, ph.stale});
         write_csr(REG_TIMEOUT, {16'd0, ph.tmo});
         write_csr(REG_PERIOD, {24'd0, ph.period});
         csr_valid <= 1'b0;
         npool = ph.pool;
         for (int k = 0; k < npool; k++) refill_pool(k);
         for (int j = 0; j < ph.n; j++) begin
            quiet = (j % 200) < 30;
            if (ph.hold && j == 60) long_hold = 1'b1;
            send_datagram(make_datagram(), 1'b0, '0);
         end
         quiet = 1'b0;
         drain();
      end

      $display("Sent %0d transactions over %0d register settings; %0d accepted, %0d completed,",
               n_items, $size(phases) + 1, status_seen[STAT_ACCEPT],
               status_seen[STAT_COMPLETE]);
      $display("  %0d duplicates, %0d conflicts, %0d stale, %0d ticks.", status_seen[STAT_DUP],
               status_seen[STAT_CONFLICT], status_seen[STAT_STALE], status_seen[STAT_TICK]);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
